### rtl/assert_macros.svh
// Assertion macros shared by the RTL; checks vanish when SYNTHESIS is set.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### rtl/fcsg_pkg.sv
// Types and constants for the filled-circle span generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fcsg_pkg;

    // field widths fixed by the stream format
    localparam int RADIUS_W   = 11;
    localparam int COORD_W    = 13;
    localparam int OUT_XY_W   = 12;
    localparam int ADDR_W     = 25;
    localparam int COLOR_W    = 32;
    localparam int SCREEN_W   = 13;
    localparam int PITCH_W    = 14;
    localparam int POS_W      = 14;  // centre +/- radius, signed
    localparam int ROW_W      = 13;  // on-screen row / column, unsigned
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 96;

    // command codes carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 2'd2;

    localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 13'd1920;
    localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 13'd1080;
    localparam logic [PITCH_W-1:0]  RST_LINE_PITCH    = 14'd1920;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROOT,
        S_EDGE,
        S_ADDR
    } t_state;

endpackage
`default_nettype wire

### rtl/filled_circle_span_generator.sv
// Filled-circle span generator: one load beat latches a circle, each next beat on it yields a span.
// Depends on fcsg_pkg and assert_macros.svh.
// Load beat: taken while idle, no result. Next beat: the root steps, the edge step and the
// address step follow in order before o_m_tvalid rises; the bit-serial square root gives
// one root bit per cycle. No new command beat is taken until the sequencer is idle again; a held
// result keeps the sequencer in its address step. Reset (synchronous, active low): no circle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module filled_circle_span_generator
    import fcsg_pkg::*;
#(
    parameter int RADIUS_BITS = 11,
    parameter int SCREEN_BITS = 12
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // configuration write channel
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [PITCH_W-1:0]     i_cfg_data,
    // command stream
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    // tdata: centre_x[12:0], centre_y[25:13], radius[36:26], fill_color[68:37], zero pad
    input  wire [IN_DATA_W-1:0]   i_s_tdata,
    // tuser: cmd
    input  wire                   i_s_tuser,
    // span stream
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    // tdata: row_y[11:0], first_x[23:12], last_x[35:24], first_address[60:36],
    //        span_color[92:61], zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // tuser: span_empty
    output logic                  o_m_tuser,
    // tlast: final row of the circle
    output logic                  o_m_tlast
);

    // effective radius width: the low RADIUS_BITS of the radius field
    localparam int RB   = (RADIUS_BITS < RADIUS_W) ? RADIUS_BITS : RADIUS_W;
    localparam int OW   = RB + 1;          // signed row offset
    localparam int NW   = 2 * RB;          // r^2 - d^2
    localparam int CNTW = $clog2(RB);
    localparam int SW   = (SCREEN_BITS + 1 > SCREEN_W) ? SCREEN_BITS + 1 : SCREEN_W;
    localparam int CW   = SW + 2;          // signed compare width
    localparam logic [SW-1:0] LIM = SW'(1) << SCREEN_BITS;
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(RB - 1);

    // ---------------- configuration registers
    logic [SCREEN_W-1:0] r_scr_w, r_scr_h;
    logic [PITCH_W-1:0]  r_pitch;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= RST_SCREEN_WIDTH;
            r_scr_h <= RST_SCREEN_HEIGHT;
            r_pitch <= RST_LINE_PITCH;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data[SCREEN_W-1:0];
                REG_LINE_PITCH:    r_pitch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input field split
    logic [COORD_W-1:0]  in_cx, in_cy;
    logic [RADIUS_W-1:0] in_rad;
    logic [COLOR_W-1:0]  in_color;

    assign in_cx    = i_s_tdata[12:0];
    assign in_cy    = i_s_tdata[25:13];
    assign in_rad   = i_s_tdata[36:26];
    assign in_color = i_s_tdata[68:37];

    // ---------------- state and sequencer
    t_state r_state, n_state;

    logic signed [COORD_W-1:0] r_cx, r_cy;
    logic [RB-1:0]             r_radius;
    logic [COLOR_W-1:0]        r_color;
    logic signed [OW-1:0]      r_offset;
    logic                      r_active;
    logic [NW-1:0]             r_n;        // r^2 - d^2 for the current row

    logic in_take, take_load, take_next, out_free;
    logic root_step, edge_step, out_load;

    assign in_take   = i_s_tvalid && o_s_tready;
    assign take_load = in_take && (i_s_tuser == CMD_LOAD);
    assign take_next = in_take && (i_s_tuser == CMD_NEXT) && r_active;
    assign out_free  = !o_m_tvalid || i_m_tready;

    logic [CNTW-1:0] r_cnt;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (take_next) n_state = S_ROOT;
            S_ROOT:  if (r_cnt == '0) n_state = S_EDGE;
            S_EDGE:  n_state = S_ADDR;
            S_ADDR:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        root_step  = 1'b0;
        edge_step  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            S_ROOT:  root_step  = 1'b1;
            S_EDGE:  edge_step  = 1'b1;
            S_ADDR:  out_load   = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // ---------------- bit-serial square root, one root bit per cycle
    logic [NW-1:0]  r_rad;   // radicand, consumed two bits at a time from the top
    logic [RB:0]    r_rem;
    logic [RB-1:0]  r_root;
    logic [RB+2:0]  rem_sh, trial, rem_sub;
    logic           take_bit;

    assign rem_sh   = {r_rem, r_rad[NW-1 -: 2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign take_bit = (rem_sh >= trial);
    assign rem_sub  = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (take_next) begin
            r_rad  <= r_n;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_LAST;
        end else if (root_step) begin
            r_rad  <= {r_rad[NW-3:0], 2'b00};
            r_rem  <= take_bit ? rem_sub[RB:0] : rem_sh[RB:0];
            r_root <= {r_root[RB-2:0], take_bit};
            r_cnt  <= r_cnt - CNTW'(1);
        end
    end

    // ---------------- edges, clipping, row advance
    logic [SW-1:0] eff_w, eff_h;
    assign eff_w = ({{(SW-SCREEN_W){1'b0}}, r_scr_w} >= LIM) ? LIM
                 : {{(SW-SCREEN_W){1'b0}}, r_scr_w};
    assign eff_h = ({{(SW-SCREEN_W){1'b0}}, r_scr_h} >= LIM) ? LIM
                 : {{(SW-SCREEN_W){1'b0}}, r_scr_h};

    logic signed [POS_W-1:0] dy, left, right, half;
    logic signed [CW-1:0]    dy_c, left_c, right_c, w_c, h_c, first_c, lastx_c;
    logic                    span_empty, fin;

    assign half  = signed'({{(POS_W-RB){1'b0}}, r_root});
    assign dy    = POS_W'(r_cy) + POS_W'(r_offset);
    assign left  = POS_W'(r_cx) - half;
    assign right = POS_W'(r_cx) + half;

    assign dy_c    = CW'(dy);
    assign left_c  = CW'(left);
    assign right_c = CW'(right);
    assign w_c     = signed'({2'b00, eff_w});
    assign h_c     = signed'({2'b00, eff_h});

    assign span_empty = (eff_w == '0) || (eff_h == '0) || (dy_c < 0) || (dy_c >= h_c) ||
                        (right_c < 0) || (left_c >= w_c);
    assign fin        = (r_offset >= signed'({1'b0, r_radius}));
    assign first_c    = (left_c < 0) ? '0 : left_c;
    assign lastx_c    = (right_c > w_c - CW'(1)) ? w_c - CW'(1) : right_c;

    // next row: n(d+1) = n(d) - (2d + 1)
    logic signed [OW:0]   step;
    logic signed [NW+1:0] n_step;
    assign step   = {r_offset, 1'b1};
    assign n_step = signed'({2'b00, r_n}) - (NW+2)'(step);

    logic [ROW_W-1:0]    r_row, r_first;
    logic [OUT_XY_W-1:0] r_lastx;
    logic                r_empty, r_fin;

    always_ff @(posedge i_clk) begin
        if (edge_step) begin
            r_empty <= span_empty;
            r_fin   <= fin;
            r_row   <= span_empty ? '0 : dy_c[ROW_W-1:0];
            r_first <= span_empty ? '0 : first_c[ROW_W-1:0];
            r_lastx <= span_empty ? '0 : lastx_c[OUT_XY_W-1:0];
        end
    end

    // held circle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_radius <= '0;
            r_color  <= '0;
            r_offset <= '0;
            r_n      <= '0;
            r_active <= 1'b0;
        end else if (take_load) begin
            r_cx     <= signed'(in_cx);
            r_cy     <= signed'(in_cy);
            r_radius <= in_rad[RB-1:0];
            r_color  <= in_color;
            r_offset <= -signed'({1'b0, in_rad[RB-1:0]});
            r_n      <= '0;              // d = -r gives r^2 - d^2 = 0
            r_active <= 1'b1;
        end else if (edge_step) begin
            if (fin) begin
                r_active <= 1'b0;
            end else begin
                r_offset <= r_offset + OW'(1);
                r_n      <= n_step[NW-1:0];
            end
        end
    end

    // ---------------- address and output register
    logic [ROW_W+PITCH_W-1:0] row_base;
    logic [ADDR_W-1:0]        addr;
    assign row_base = r_row * r_pitch;
    assign addr     = ADDR_W'(row_base) + ADDR_W'(r_first);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (out_load) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_m_tdata <= {3'b000, r_color, addr, r_lastx, r_first[OUT_XY_W-1:0],
                          r_row[OUT_XY_W-1:0]};
            o_m_tuser <= r_empty;
            o_m_tlast <= r_fin;
        end
    end

    // ---------------- checks
    `ASSERT_PROP(a_out_from_addr, i_clk, i_rst_n, $rose(o_m_tvalid) |-> $past(r_state == S_ADDR))
    `ASSERT_PROP(a_empty_zeroed, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[60:0] == '0))
    `ASSERT_PROP(a_last_ends, i_clk, i_rst_n, ($rose(o_m_tvalid) && o_m_tlast) |-> !r_active)
    `ASSERT_PROP(a_half_le_r, i_clk, i_rst_n, (r_state == S_EDGE) |-> (r_root <= r_radius))
    `ASSERT_NEVER(a_offset_range, i_clk, i_rst_n, r_active && (r_offset > signed'({1'b0, r_radius})))

endmodule
`default_nettype wire

### test/filled_circle_span_generator_tb.sv
// Self-checking bench for filled_circle_span_generator: command and span streams, config port.
// Depends on fcsg_pkg and the block's RTL; predicts every span in-bench and checks it per field.
`timescale 1ns / 1ps
module filled_circle_span_generator_tb;
    import fcsg_pkg::*;

    localparam int SCREEN_LIM = 4096;  // 2^SCREEN_BITS, saturation point of width/height
    localparam int SETTLE     = 40;    // idle cycles after the last span

    // one command beat as the driver sees it
    typedef struct {
        logic                cmd;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [RADIUS_W-1:0] radius;
        logic [COLOR_W-1:0]  color;
    } t_cmd;

    // one span beat, unpacked
    typedef struct {
        logic [OUT_XY_W-1:0] row_y;
        logic [OUT_XY_W-1:0] first_x;
        logic [OUT_XY_W-1:0] last_x;
        logic [ADDR_W-1:0]   first_address;
        logic [COLOR_W-1:0]  span_color;
        logic                span_empty;
        logic                last;
    } t_span;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [PITCH_W-1:0]     i_cfg_data = '0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata = '0;
    logic                   i_s_tuser = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   o_m_tuser;
    logic                   o_m_tlast;

    filled_circle_span_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench copy of the registers
    int scr_width  = int'(RST_SCREEN_WIDTH);
    int scr_height = int'(RST_SCREEN_HEIGHT);
    int scr_pitch  = int'(RST_LINE_PITCH);

    // bench copy of the circle state
    int          held_cx;
    int          held_cy;
    int          held_rad;
    logic [31:0] held_color;
    int          row_ofs;
    bit          circle_on;

    t_cmd  cmd_q[$];     // commands waiting for the driver
    t_span span_q[$];    // spans predicted, not yet seen
    t_cmd  cur_cmd;      // command on the bus now
    bit    s_fire;       // command beat taken at the last rising edge
    bit    m_fire;       // span beat taken at the last rising edge
    bit    burst_mode;   // no idling on either side
    int    cmd_gap;
    int    span_stall;
    int    errors;

    // exact floor square root, one result bit at a time from the top
    function automatic int floor_root(input int n);
        int root;
        int trial;
        int b;
        root = 0;
        for (b = 11; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic int draw_wait();
        return burst_mode ? 0 : int'($urandom_range(0, 10));
    endfunction

    // advance the bench state by one accepted command; queue the span it yields
    task automatic apply_command(input t_cmd c);
        t_span s;
        int w, h, r2, d2, half, dy, left, right, first, lastc, addr;
        bit empty, fin;
        if (c.cmd == CMD_LOAD) begin
            held_cx    = int'($signed(c.cx));
            held_cy    = int'($signed(c.cy));
            held_rad   = int'(c.radius);
            held_color = c.color;
            row_ofs    = -held_rad;
            circle_on  = 1'b1;
            return;
        end
        if (!circle_on)
            return;  // next beat with nothing loaded: ignored
        w = (scr_width  > SCREEN_LIM) ? SCREEN_LIM : scr_width;
        h = (scr_height > SCREEN_LIM) ? SCREEN_LIM : scr_height;
        r2 = held_rad * held_rad;
        d2 = row_ofs * row_ofs;
        half = floor_root((r2 >= d2) ? r2 - d2 : 0);
        dy = held_cy + row_ofs;
        left = held_cx - half;
        right = held_cx + half;
        empty = (w == 0) || (h == 0) || (dy < 0) || (dy >= h) || (right < 0) || (left >= w);
        fin = (row_ofs >= held_rad);
        s.span_color = held_color;
        s.span_empty = empty;
        s.last = fin;
        if (empty) begin
            s.row_y = '0;
            s.first_x = '0;
            s.last_x = '0;
            s.first_address = '0;
        end else begin
            first = (left < 0) ? 0 : left;
            lastc = (right > w - 1) ? w - 1 : right;
            addr = dy * scr_pitch + first;  // wraps to 25 bits below
            s.row_y = dy[11:0];
            s.first_x = first[11:0];
            s.last_x = lastc[11:0];
            s.first_address = addr[24:0];
        end
        span_q.push_back(s);
        if (fin)
            circle_on = 1'b0;
        else
            row_ofs++;
    endtask

    // check spans and predict from commands, both at the rising edge
    always @(posedge i_clk) begin
        t_span got;
        t_span want;
        if (!i_rst_n) begin
            s_fire <= 1'b0;
            m_fire <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.row_y = o_m_tdata[11:0];
                got.first_x = o_m_tdata[23:12];
                got.last_x = o_m_tdata[35:24];
                got.first_address = o_m_tdata[60:36];
                got.span_color = o_m_tdata[92:61];
                got.span_empty = o_m_tuser;
                got.last = o_m_tlast;
                if (span_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: span beat with none expected", $realtime);
                end else begin
                    want = span_q.pop_front();
                    if (got.row_y !== want.row_y || got.first_x !== want.first_x ||
                        got.last_x !== want.last_x ||
                        got.first_address !== want.first_address ||
                        got.span_color !== want.span_color ||
                        got.span_empty !== want.span_empty || got.last !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: span mismatch exp row %0d x %0d..%0d addr %0d ",
                                      "col %h empty %0b last %0b / got row %0d x %0d..%0d ",
                                      "addr %0d col %h empty %0b last %0b"}, $realtime,
                                     want.row_y, want.first_x, want.last_x,
                                     want.first_address, want.span_color, want.span_empty,
                                     want.last, got.row_y, got.first_x, got.last_x,
                                     got.first_address, got.span_color, got.span_empty,
                                     got.last);
                    end
                end
            end
            if (i_s_tvalid && o_s_tready)
                apply_command(cur_cmd);
            s_fire <= i_s_tvalid && o_s_tready;
            m_fire <= o_m_tvalid && i_m_tready;
        end
    end

    // command driver: falling edge, a fresh gap drawn after every beat
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_fire)
                cmd_gap = draw_wait();
            if (!i_s_tvalid || s_fire) begin
                if (cmd_gap > 0) begin
                    cmd_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cur_cmd = cmd_q.pop_front();
                    i_s_tdata <= {3'b000, cur_cmd.color, cur_cmd.radius, cur_cmd.cy,
                                  cur_cmd.cx};
                    i_s_tuser <= cur_cmd.cmd;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // span sink: falling edge, a fresh stall drawn after every beat
    always @(negedge i_clk) begin
        if (m_fire)
            span_stall = draw_wait();
        if (span_stall > 0) begin
            span_stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic push_load(input int cx, input int cy, input int rad, input logic [31:0] col);
        t_cmd c;
        c.cmd = CMD_LOAD;
        c.cx = cx[12:0];
        c.cy = cy[12:0];
        c.radius = rad[10:0];
        c.color = col;
        cmd_q.push_back(c);
    endtask

    // next beats carry random junk in the unused fields
    task automatic push_next(input int n);
        t_cmd c;
        repeat (n) begin
            c.cmd = CMD_NEXT;
            c.cx = COORD_W'($urandom);
            c.cy = COORD_W'($urandom);
            c.radius = RADIUS_W'($urandom);
            c.color = $urandom;
            cmd_q.push_back(c);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PITCH_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_SCREEN_WIDTH:  scr_width = int'(val[12:0]);
            REG_SCREEN_HEIGHT: scr_height = int'(val[12:0]);
            REG_LINE_PITCH:    scr_pitch = int'(val);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every command taken and every span seen, then let the block settle
    task automatic drain();
        while (cmd_q.size() != 0 || i_s_tvalid || span_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // centre coordinate: mostly around the visible area, sometimes anywhere
    function automatic int pick_pos(input int lim);
        int p;
        if ($urandom_range(0, 3) != 0)
            p = int'($urandom_range(0, lim + 60)) - 30;
        else
            p = int'($urandom_range(0, 8191)) - 4096;
        if (p > 4095)
            p = 4095;
        return p;
    endfunction

    function automatic int pick_radius();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return $urandom_range(0, 12);
        else if (p < 92)
            return $urandom_range(13, 40);
        return $urandom_range(41, 2047);
    endfunction

    // random traffic: mostly whole circles, some cut short, some stray next beats
    task automatic queue_random(input int budget);
        int done, kind, rad, rows, lim_x, lim_y;
        done = 0;
        lim_x = (scr_width  > SCREEN_LIM) ? SCREEN_LIM : scr_width;
        lim_y = (scr_height > SCREEN_LIM) ? SCREEN_LIM : scr_height;
        while (done < budget) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                rad = pick_radius();
                push_load(pick_pos(lim_x), pick_pos(lim_y), rad, $urandom);
                // big circles can take thousands of rows: only their top is walked
                rows = (rad <= 40) ? 2 * rad + 1 : int'($urandom_range(1, 24));
                push_next(rows);
                done += 1 + rows;
                if ($urandom_range(0, 4) == 0)
                    push_next($urandom_range(1, 2));  // ignored past the end of a small circle
            end else if (kind < 90) begin
                rows = $urandom_range(0, 5);
                push_load(pick_pos(lim_x), pick_pos(lim_y), pick_radius(), $urandom);
                push_next(rows);
                done += 1 + rows;
            end else begin
                rows = $urandom_range(1, 3);
                push_next(rows);
                done += rows;
            end
        end
    endtask

    task automatic run_phase(input int w, input int h, input int p, input int budget,
                             input bit burst);
        write_reg(REG_SCREEN_WIDTH, PITCH_W'(w));
        write_reg(REG_SCREEN_HEIGHT, PITCH_W'(h));
        write_reg(REG_LINE_PITCH, PITCH_W'(p));
        burst_mode = burst;
        queue_random(budget);
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset registers (1920 x 1080, pitch 1920)
        push_next(1);                                   // next with nothing loaded
        push_load(100, 100, 0, 32'h1234_5678);          // radius zero: one pixel, last
        push_next(2);                                   // second next is past the end
        push_load(0, 0, 2, 32'hFFFF_FFFF);              // clipped top and left
        push_next(5);
        push_load(-4096, 4095, 3, 32'h0000_0000);       // extreme centres, off screen
        push_next(2);
        push_load(1919, 1079, 1, 32'hA5A5_5A5A);        // reload mid-circle
        push_next(3);
        push_load(4095, -4096, 2047, 32'h8000_0001);    // largest radius
        push_next(2);
        push_load(960, 0, 4, 32'h5A5A_A5A5);
        push_next(2);
        drain();

        run_phase(4096, 4096, 8192, 170, 1'b0);
        run_phase(1, 1, 1, 110, 1'b0);                  // one-pixel screen
        run_phase(0, 0, 16383, 80, 1'b0);               // zero-sized screen: all empty
        run_phase(8191, 8191, 16383, 170, 1'b0);        // saturated size, address wrap
        run_phase(64, 48, 64, 170, 1'b1);
        run_phase($urandom_range(1, 4096), $urandom_range(1, 4096),
                  $urandom_range(1, 8192), 170, 1'b0);
        run_phase($urandom_range(1, 4096), $urandom_range(1, 4096),
                  $urandom_range(1, 8192), 100, 1'b1);
        run_phase(1920, 1080, 1920, 100, 1'b0);

        if (errors == 0)
            $display("[filled_circle_span_generator] OK");
        else
            $display("[filled_circle_span_generator] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("[filled_circle_span_generator] ERROR");
        $finish;
    end

endmodule

### filled_circle_span_generator.f
+incdir+rtl
rtl/fcsg_pkg.sv
rtl/filled_circle_span_generator.sv
test/filled_circle_span_generator_tb.sv
